@@ rtl/bqpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bqpe_pkg: shared definitions for the byte queue with positional edit
// Request and response codes, word layouts and default sizing.
// ----------------------------------------------------------------------------
package bqpe_pkg;

   localparam int DEPTH_DEFAULT = 64;

   // request word fields, lowest bit up
   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 8;
   localparam int POSITION_W = 7;
   localparam int REQ_W      = 24;

   // response word fields, lowest bit up
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int RSP_USED = VALUE_W + 1 + COUNT_W + STATUS_W;
   localparam int RSP_W    = 24;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam action_type ACT_APPEND = 3'd0;
   localparam action_type ACT_REMOVE = 3'd1;
   localparam action_type ACT_INSERT = 3'd2;
   localparam action_type ACT_DELETE = 3'd3;
   localparam action_type ACT_SEARCH = 3'd4;
   localparam action_type ACT_CLEAR  = 3'd5;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

endpackage

@@ rtl/byte_queue_positional_edit_core.sv @@
// ----------------------------------------------------------------------------
// byte_queue_positional_edit_core: bounded byte queue with positional edit
// Append, remove front, insert, delete, search and clear on a RAM-held queue.
// ----------------------------------------------------------------------------
// The queue lives in one RAM as a ring with a head pointer, so append, clear
// and remove-front touch at most one entry; every request returns exactly one
// response word. A request is taken only when the core is idle and occupies
// it until its response is placed in the output register; the next request
// is accepted while that response waits. Insert walks from the back down to
// position n, delete from position n+1 to the back, and search over every
// entry, where n is the 1-based position. Walks move one entry per cycle,
// paced by the single read port of the RAM. A response still waiting in the
// output register holds the core in its last state. Error statuses report
// empty, full, or a position outside 1..count.
// ----------------------------------------------------------------------------
module byte_queue_positional_edit_core #(
   parameter int DEPTH = bqpe_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: action[2:0], value[10:3], position[17:11], zero fill
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bqpe_pkg::REQ_W-1:0] req_tdata,
   // rsp_tdata: value_out[7:0], found[8], count[15:9], status[17:16], zero fill
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bqpe_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > bqpe_pkg::POSITION_W) ? CW : bqpe_pkg::POSITION_W;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_POP     = 3'd2;
   localparam logic [2:0] S_INS     = 3'd3;
   localparam logic [2:0] S_INS_PUT = 3'd4;
   localparam logic [2:0] S_DEL     = 3'd5;
   localparam logic [2:0] S_SEARCH  = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0]                         state_ff, state_in;
   bqpe_pkg::action_type               act_ff, act_in;
   logic [bqpe_pkg::VALUE_W-1:0]       val_ff, val_in;
   logic [bqpe_pkg::POSITION_W-1:0]    pos_ff, pos_in;
   logic [AW-1:0]                      head_ff, head_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [AW-1:0]                      walk_ff, walk_in;
   logic                               found_ff, found_in;
   logic [bqpe_pkg::VALUE_W-1:0]       vout_ff, vout_in;
   bqpe_pkg::status_type               status_ff, status_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bqpe_pkg::RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   logic                               mem_wr_en;
   logic [AW-1:0]                      mem_wr_idx;
   logic [bqpe_pkg::VALUE_W-1:0]       mem_wr_data;
   logic                               mem_rd_en;
   logic [AW-1:0]                      mem_rd_idx;
   logic [bqpe_pkg::VALUE_W-1:0]       mem_rd_data;

   logic                               req_fire;
   logic                               is_full;
   logic                               is_empty;
   logic                               pos_bad;
   logic                               pos_last;
   logic [AW-1:0]                      edit_idx;
   logic [AW-1:0]                      last_idx;
   logic [bqpe_pkg::COUNT_W-1:0]       count_out;

   // logical index to ring address; both terms stay below DEPTH
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] idx);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, idx};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   bqpe_ram #(
      .WIDTH (bqpe_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ring_addr(head_ff, mem_wr_idx)),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ring_addr(head_ff, mem_rd_idx)),
      .rd_data (mem_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign pos_bad   = (pos_ff == '0) || (CMP_W'(pos_ff) > CMP_W'(count_ff));
   assign pos_last  = (CMP_W'(pos_ff) == CMP_W'(count_ff));
   assign edit_idx  = AW'(CMP_W'(pos_ff) - CMP_W'(1));
   assign last_idx  = AW'(count_ff - CW'(1));
   assign count_out = bqpe_pkg::COUNT_W'(count_ff);

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      found_in     = found_ff;
      vout_in      = vout_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_idx   = walk_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_idx   = walk_ff;

      // drain the output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in    = req_tdata[bqpe_pkg::ACTION_W-1:0];
               val_in    = req_tdata[bqpe_pkg::ACTION_W +: bqpe_pkg::VALUE_W];
               pos_in    = req_tdata[bqpe_pkg::ACTION_W + bqpe_pkg::VALUE_W +:
                                     bqpe_pkg::POSITION_W];
               found_in  = 1'b0;
               vout_in   = '0;
               status_in = bqpe_pkg::ST_OK;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            unique case (act_ff)
               bqpe_pkg::ACT_APPEND: begin
                  if (is_full) begin
                     status_in = bqpe_pkg::ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_idx  = AW'(count_ff);
                     mem_wr_data = val_ff;
                     count_in    = count_ff + CW'(1);
                  end
               end
               bqpe_pkg::ACT_REMOVE: begin
                  if (is_empty) begin
                     status_in = bqpe_pkg::ST_EMPTY;
                  end else begin
                     mem_rd_en  = 1'b1;
                     mem_rd_idx = '0;
                     state_in   = S_POP;
                  end
               end
               bqpe_pkg::ACT_INSERT: begin
                  if (is_full) begin
                     status_in = bqpe_pkg::ST_FULL;
                  end else if (pos_bad) begin
                     status_in = bqpe_pkg::ST_RANGE;
                  end else begin
                     // walk down from the back, moving each entry up by one
                     mem_rd_en  = 1'b1;
                     mem_rd_idx = last_idx;
                     walk_in    = last_idx;
                     state_in   = S_INS;
                  end
               end
               bqpe_pkg::ACT_DELETE: begin
                  if (is_empty) begin
                     status_in = bqpe_pkg::ST_EMPTY;
                  end else if (pos_bad) begin
                     status_in = bqpe_pkg::ST_RANGE;
                  end else if (pos_last) begin
                     count_in = count_ff - CW'(1);
                  end else begin
                     mem_rd_en  = 1'b1;
                     mem_rd_idx = edit_idx + AW'(1);
                     walk_in    = edit_idx + AW'(1);
                     state_in   = S_DEL;
                  end
               end
               bqpe_pkg::ACT_SEARCH: begin
                  if (!is_empty) begin
                     mem_rd_en  = 1'b1;
                     mem_rd_idx = '0;
                     walk_in    = '0;
                     state_in   = S_SEARCH;
                  end
               end
               bqpe_pkg::ACT_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_POP: begin
            vout_in  = mem_rd_data;
            head_in  = ring_addr(head_ff, AW'(1));
            count_in = count_ff - CW'(1);
            state_in = S_DONE;
         end
         S_INS: begin
            mem_wr_en  = 1'b1;
            mem_wr_idx = walk_ff + AW'(1);
            if (walk_ff == edit_idx) begin
               state_in = S_INS_PUT;
            end else begin
               mem_rd_en  = 1'b1;
               mem_rd_idx = walk_ff - AW'(1);
               walk_in    = walk_ff - AW'(1);
            end
         end
         S_INS_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_idx  = edit_idx;
            mem_wr_data = val_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_DONE;
         end
         S_DEL: begin
            mem_wr_en  = 1'b1;
            mem_wr_idx = walk_ff - AW'(1);
            if (walk_ff == last_idx) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               mem_rd_en  = 1'b1;
               mem_rd_idx = walk_ff + AW'(1);
               walk_in    = walk_ff + AW'(1);
            end
         end
         S_SEARCH: begin
            if (mem_rd_data == val_ff) begin
               found_in = 1'b1;
            end
            if (walk_ff == last_idx) begin
               state_in = S_DONE;
            end else begin
               mem_rd_en  = 1'b1;
               mem_rd_idx = walk_ff + AW'(1);
               walk_in    = walk_ff + AW'(1);
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(bqpe_pkg::RSP_W - bqpe_pkg::RSP_USED)'(0),
                               status_ff, count_out, found_ff, vout_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      walk_ff     <= walk_in;
      found_ff    <= found_in;
      vout_ff     <= vout_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/bqpe_ram.sv @@
// ----------------------------------------------------------------------------
// bqpe_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bqpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bqpe_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
